[src/dcv_pkg.sv]
// Shared constants, types and state encoding for the disc collision velocity update.
package dcv_pkg;
   localparam int MAX_BALLS = 64;
   localparam int IDX_W = 6;
   localparam int CNT_W = 7;
   localparam int D_W = 35;
   localparam int V_W = 18;
   localparam int Q_W = 17;

   typedef struct packed {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [9:0] radius;
      logic [15:0] mass;
   } disc_type;

   typedef struct packed {
      logic start;
      logic neg;
   } div_ctl_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_I, ST_RD_J, ST_CAP_J, ST_RECT, ST_SQX, ST_SQY, ST_SQR, ST_CMP,
      ST_MUL1, ST_MUL2, ST_DIV_GO, ST_DIV_WAIT, ST_WR_I, ST_WR_J, ST_NEXT,
      ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
   } state_type;
endpackage

[src/dcv_req_if.sv]
// Input channel carrying one disc word.
interface dcv_req_if;
   logic valid;
   logic ready;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   logic [9:0] radius;
   logic [15:0] mass;
   logic last;
   modport source (output valid, pos_x, pos_y, vel_x, vel_y, radius, mass, last,
                   input ready);
   modport sink (input valid, pos_x, pos_y, vel_x, vel_y, radius, mass, last,
                 output ready);
endinterface

[src/dcv_rsp_if.sv]
// Result channel carrying one updated velocity word.
interface dcv_rsp_if;
   logic valid;
   logic ready;
   logic [5:0] ball_index;
   logic signed [15:0] new_vel_x;
   logic signed [15:0] new_vel_y;
   logic [31:0] bounce_total;
   logic last_result;
   modport source (output valid, ball_index, new_vel_x, new_vel_y, bounce_total,
                   last_result, input ready);
   modport sink (input valid, ball_index, new_vel_x, new_vel_y, bounce_total,
                 last_result, output ready);
endinterface

[src/disc_collision_velocity_update.sv]
// Top level: disc store, pairwise collision sequencer and result emitter.
// Loading accepts one disc per cycle while idle; the word with last set starts the pass.
// A pair that fails the box cut goes to the next pair, one that passes reaches the radial cut,
// and a colliding pair runs one shared 17-step divider once per velocity component.
// Results leave one at a time after the whole pass, each held until the receiver takes it.
// Synchronous reset clears the disc count, bounce count, watched index and control.
module disc_collision_velocity_update
   import dcv_pkg::*;
(
   input  logic clock,
   input  logic reset,
   dcv_req_if.sink req_if,
   dcv_rsp_if.source rsp_if,
   input  logic csr_write_enable,
   input  logic [5:0] csr_write_data
);
   disc_type disc_mem [MAX_BALLS];
   logic [31:0] vel_mem [MAX_BALLS];
   disc_type disc_rd;
   logic [31:0] vel_rd;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff;
   logic [31:0] bounce_ff;
   logic [IDX_W-1:0] watched_ff;
   logic [IDX_W-1:0] i_ff, j_ff, out_ff;
   logic [1:0] k_ff;
   disc_type di_ff, dj_ff;
   logic [31:0] vi_ff, vj_ff;
   logic signed [16:0] dx_ff, dy_ff;
   logic [10:0] rs_ff;
   logic [32:0] acc_ff;
   logic [46:0] lhs_ff;
   logic [21:0] rsq_ff;
   logic signed [32:0] p1_ff, p2_ff;
   logic [15:0] nv_ff [4];
   logic rsp_valid_ff;
   logic [5:0] rsp_idx_ff;
   logic [31:0] rsp_vel_ff;
   logic [31:0] rsp_bounce_ff;
   logic rsp_last_ff;

   logic accept, room, mem_we, vel_we, rect_ok, rad_ok, hit_watched;
   logic [IDX_W-1:0] rd_addr, vel_waddr;
   logic [31:0] vel_wdata;
   logic [CNT_W-1:0] n_new;
   logic [20:0] span, ax5, bx5, ay5, by5;
   logic signed [33:0] sqx, sqy;
   logic [35:0] rhs;
   logic [16:0] den;
   logic signed [15:0] va, vb;
   logic [15:0] ma, mb;
   logic signed [16:0] mdiff;
   logic signed [32:0] p1_calc, p2_calc;
   logic signed [34:0] num;
   logic [33:0] mag;
   logic [D_W-1:0] dividend;
   div_ctl_type div_ctl;
   logic div_done;
   logic [15:0] div_result;
   logic pair_more, row_more;

   assign room = count_ff < CNT_W'(MAX_BALLS);
   assign accept = req_if.valid && req_if.ready;
   assign n_new = room ? count_ff + CNT_W'(1) : count_ff;

   assign span = 21'(di_ff.radius) * 21'd6 + 21'(dj_ff.radius) * 21'd5;
   assign ax5 = 21'(di_ff.pos_x) * 21'd5;
   assign bx5 = 21'(dj_ff.pos_x) * 21'd5;
   assign ay5 = 21'(di_ff.pos_y) * 21'd5;
   assign by5 = 21'(dj_ff.pos_y) * 21'd5;
   assign rect_ok = (ax5 + span > bx5) && (ax5 < bx5 + span)
                 && (ay5 + span > by5) && (ay5 < by5 + span);
   assign sqx = dx_ff * dx_ff;
   assign sqy = dy_ff * dy_ff;
   assign rhs = 36'(rsq_ff) * 36'd10201;
   assign rad_ok = lhs_ff < 47'(rhs);
   assign hit_watched = (i_ff == watched_ff) || (j_ff == watched_ff);
   assign den = 17'(di_ff.mass) + 17'(dj_ff.mass);

   always_comb begin
      case (k_ff)
         2'd0: begin
            va = vi_ff[31:16]; vb = vj_ff[31:16]; ma = di_ff.mass; mb = dj_ff.mass;
         end
         2'd1: begin
            va = vi_ff[15:0]; vb = vj_ff[15:0]; ma = di_ff.mass; mb = dj_ff.mass;
         end
         2'd2: begin
            va = vj_ff[31:16]; vb = vi_ff[31:16]; ma = dj_ff.mass; mb = di_ff.mass;
         end
         default: begin
            va = vj_ff[15:0]; vb = vi_ff[15:0]; ma = dj_ff.mass; mb = di_ff.mass;
         end
      endcase
   end

   assign mdiff = $signed({1'b0, ma}) - $signed({1'b0, mb});
   assign p1_calc = va * mdiff;
   assign p2_calc = $signed({1'b0, mb}) * vb;
   assign num = 35'(p1_ff) + (35'(p2_ff) <<< 1);
   assign mag = num[34] ? 34'(-num) : num[33:0];
   assign dividend = {mag, 1'b0} + D_W'(den);

   assign pair_more = (7'(j_ff) + 7'd1) < count_ff;
   assign row_more = (7'(i_ff) + 7'd2) < count_ff;

   dcv_div u_div (
      .clock(clock),
      .reset(reset),
      .ctl(div_ctl),
      .dividend(dividend),
      .divisor({den, 1'b0}),
      .done(div_done),
      .result(div_result)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_if.last) begin
               state_in = (n_new >= CNT_W'(2)) ? ST_RD_I : ST_OUT_RD;
            end
         end
         ST_RD_I: state_in = ST_RD_J;
         ST_RD_J: state_in = ST_CAP_J;
         ST_CAP_J: state_in = ST_RECT;
         ST_RECT: state_in = rect_ok ? ST_SQX : ST_NEXT;
         ST_SQX: state_in = ST_SQY;
         ST_SQY: state_in = ST_SQR;
         ST_SQR: state_in = ST_CMP;
         ST_CMP: begin
            if (rad_ok && den != 17'd0) begin
               state_in = ST_MUL1;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_DIV_GO;
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = (k_ff == 2'd3) ? ST_WR_I : ST_MUL1;
            end
         end
         ST_WR_I: state_in = ST_WR_J;
         ST_WR_J: state_in = ST_NEXT;
         ST_NEXT: state_in = (pair_more || row_more) ? ST_RD_I : ST_OUT_RD;
         ST_OUT_RD: state_in = ST_OUT_LD;
         ST_OUT_LD: state_in = ST_OUT_WAIT;
         ST_OUT_WAIT: begin
            if (rsp_if.ready) begin
               state_in = rsp_last_ff ? ST_IDLE : ST_OUT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      mem_we = accept && room;
      vel_we = mem_we;
      vel_waddr = count_ff[IDX_W-1:0];
      vel_wdata = {req_if.vel_x, req_if.vel_y};
      rd_addr = i_ff;
      div_ctl.start = (state_ff == ST_DIV_GO);
      div_ctl.neg = num[34];
      case (state_ff)
         ST_RD_J: rd_addr = j_ff;
         ST_OUT_RD: rd_addr = out_ff;
         ST_WR_I: begin
            vel_we = 1'b1;
            vel_waddr = i_ff;
            vel_wdata = {nv_ff[0], nv_ff[1]};
         end
         ST_WR_J: begin
            vel_we = 1'b1;
            vel_waddr = j_ff;
            vel_wdata = {nv_ff[2], nv_ff[3]};
         end
         default: rd_addr = i_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         disc_mem[count_ff[IDX_W-1:0]] <= '{pos_x: req_if.pos_x, pos_y: req_if.pos_y,
                                            radius: req_if.radius, mass: req_if.mass};
      end
      if (vel_we) begin
         vel_mem[vel_waddr] <= vel_wdata;
      end
      disc_rd <= disc_mem[rd_addr];
      vel_rd <= vel_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_RD_J: begin
            di_ff <= disc_rd;
            vi_ff <= vel_rd;
         end
         ST_CAP_J: begin
            dj_ff <= disc_rd;
            vj_ff <= vel_rd;
         end
         ST_RECT: begin
            dx_ff <= $signed({1'b0, dj_ff.pos_x}) - $signed({1'b0, di_ff.pos_x});
            dy_ff <= $signed({1'b0, dj_ff.pos_y}) - $signed({1'b0, di_ff.pos_y});
            rs_ff <= 11'(di_ff.radius) + 11'(dj_ff.radius);
            k_ff <= 2'd0;
         end
         ST_SQX: acc_ff <= sqx[32:0];
         ST_SQY: acc_ff <= acc_ff + sqy[32:0];
         ST_SQR: begin
            lhs_ff <= 47'(acc_ff) * 47'd10000;
            rsq_ff <= 22'(rs_ff) * 22'(rs_ff);
         end
         ST_MUL1: p1_ff <= p1_calc;
         ST_MUL2: p2_ff <= p2_calc;
         ST_DIV_WAIT: begin
            if (div_done) begin
               nv_ff[k_ff] <= div_result;
               k_ff <= k_ff + 2'd1;
            end
         end
         ST_OUT_LD: begin
            rsp_idx_ff <= out_ff;
            rsp_vel_ff <= vel_rd;
            rsp_bounce_ff <= bounce_ff;
            rsp_last_ff <= (7'(out_ff) + 7'd1) == count_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         bounce_ff <= '0;
         watched_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         out_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            watched_ff <= csr_write_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  count_ff <= n_new;
                  i_ff <= '0;
                  j_ff <= IDX_W'(1);
                  out_ff <= '0;
               end
            end
            ST_CMP: begin
               if (rad_ok && hit_watched) begin
                  bounce_ff <= bounce_ff + 32'd1;
               end
            end
            ST_NEXT: begin
               if (pair_more) begin
                  j_ff <= j_ff + IDX_W'(1);
               end else if (row_more) begin
                  i_ff <= i_ff + IDX_W'(1);
                  j_ff <= i_ff + IDX_W'(2);
               end
            end
            ST_OUT_LD: rsp_valid_ff <= 1'b1;
            ST_OUT_WAIT: begin
               if (rsp_if.ready) begin
                  rsp_valid_ff <= 1'b0;
                  out_ff <= out_ff + IDX_W'(1);
                  if (rsp_last_ff) begin
                     count_ff <= '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.ball_index = rsp_idx_ff;
   assign rsp_if.new_vel_x = rsp_vel_ff[31:16];
   assign rsp_if.new_vel_y = rsp_vel_ff[15:0];
   assign rsp_if.bounce_total = rsp_bounce_ff;
   assign rsp_if.last_result = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_OUT_WAIT)
      else $error("Result word valid outside the emit wait state.");
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("Divider finished while the sequencer was not waiting for it.");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BALLS))
      else $error("Disc count exceeds the store depth.");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_I) |-> i_ff < j_ff && 7'(j_ff) < count_ff)
      else $error("Pair indices out of order or beyond the loaded discs.");
endmodule

[src/dcv_div.sv]
// Restoring divider with rounding and saturation to a signed 16-bit velocity.
module dcv_div
   import dcv_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  div_ctl_type ctl,
   input  logic [D_W-1:0] dividend,
   input  logic [V_W-1:0] divisor,
   output logic done,
   output logic [15:0] result
);
   logic [V_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0] low_ff, low_in;
   logic [Q_W-1:0] q_ff, q_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic neg_ff, neg_in;
   logic [V_W:0] trial;

   assign trial = {rem_ff, low_ff[Q_W-1]};

   always_comb begin
      rem_in = rem_ff;
      low_in = low_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in = neg_ff;
      if (ctl.start) begin
         rem_in = dividend[D_W-1:Q_W];
         low_in = dividend[Q_W-1:0];
         q_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
         neg_in = ctl.neg;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = V_W'(trial - {1'b0, divisor});
            q_in = {q_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in = trial[V_W-1:0];
            q_in = {q_ff[Q_W-2:0], 1'b0};
         end
         low_in = {low_ff[Q_W-2:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      if (neg_ff) begin
         result = (q_ff > Q_W'(32768)) ? 16'h8000 : 16'(-q_ff);
      end else begin
         result = (q_ff > Q_W'(32767)) ? 16'h7FFF : q_ff[15:0];
      end
   end

   assign done = done_ff;
endmodule

[dv/disc_collision_velocity_update_tb_if.sv]
// Testbench note: the channel interfaces come from the RTL sources; this file holds the word types.
`timescale 1ns / 1ps
package dcv_tb_pkg;
   typedef struct {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] vel_x;
      logic [15:0] vel_y;
      logic [9:0] radius;
      logic [15:0] mass;
      logic last;
   } disc_word_type;

   typedef struct {
      logic [5:0] ball_index;
      logic [15:0] new_vel_x;
      logic [15:0] new_vel_y;
      logic [31:0] bounce_total;
      logic last_result;
   } velocity_word_type;
endpackage

[dv/testbench.sv]
// Self-checking testbench for the disc collision velocity update block.
`timescale 1ns / 1ps
module testbench;
   import dcv_pkg::*;
   import dcv_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [5:0] csr_write_data = '0;

   dcv_req_if req_if ();
   dcv_rsp_if rsp_if ();

   disc_collision_velocity_update dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [15:0] disc_pos_x [MAX_BALLS];
   logic [15:0] disc_pos_y [MAX_BALLS];
   logic [15:0] disc_vel_x [MAX_BALLS];
   logic [15:0] disc_vel_y [MAX_BALLS];
   logic [9:0] disc_radius [MAX_BALLS];
   logic [15:0] disc_mass [MAX_BALLS];
   int loaded_count = 0;
   logic [31:0] bounce_count = '0;
   logic [5:0] watched_index = '0;
   velocity_word_type expected_velocities [$];
   int error_count = 0;
   int words_sent = 0;
   int results_seen = 0;
   int sets_done = 0;

   function automatic logic [15:0] elastic_velocity(longint va, longint vb, longint ma,
                                                    longint mb);
      longint den, num, mag, q;
      den = ma + mb;
      num = va * (ma - mb) + 2 * mb * vb;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      if (num < 0) begin
         if (q > 32768) q = 32768;
         return 16'(-q);
      end
      if (q > 32767) q = 32767;
      return 16'(q);
   endfunction

   function automatic bit axis_overlap(longint a, longint b, longint span);
      return (5 * a + span > 5 * b) && (5 * a < 5 * b + span);
   endfunction

   function automatic void collide_discs(int i, int j);
      longint r1, r2, span, dx, dy, rs, m1, m2, v1x, v1y, v2x, v2y;
      r1 = disc_radius[i];
      r2 = disc_radius[j];
      span = 6 * r1 + 5 * r2;
      if (!axis_overlap(disc_pos_x[i], disc_pos_x[j], span)) return;
      if (!axis_overlap(disc_pos_y[i], disc_pos_y[j], span)) return;
      dx = longint'(disc_pos_x[j]) - longint'(disc_pos_x[i]);
      dy = longint'(disc_pos_y[j]) - longint'(disc_pos_y[i]);
      rs = r1 + r2;
      if (!((dx * dx + dy * dy) * 10000 < rs * rs * 10201)) return;
      if (i == watched_index || j == watched_index) bounce_count++;
      m1 = disc_mass[i];
      m2 = disc_mass[j];
      if (m1 + m2 == 0) return;
      v1x = longint'($signed(disc_vel_x[i]));
      v1y = longint'($signed(disc_vel_y[i]));
      v2x = longint'($signed(disc_vel_x[j]));
      v2y = longint'($signed(disc_vel_y[j]));
      disc_vel_x[i] = elastic_velocity(v1x, v2x, m1, m2);
      disc_vel_y[i] = elastic_velocity(v1y, v2y, m1, m2);
      disc_vel_x[j] = elastic_velocity(v2x, v1x, m2, m1);
      disc_vel_y[j] = elastic_velocity(v2y, v1y, m2, m1);
   endfunction

   function automatic void predict_disc(disc_word_type w);
      velocity_word_type r;
      if (loaded_count < MAX_BALLS) begin
         disc_pos_x[loaded_count] = w.pos_x;
         disc_pos_y[loaded_count] = w.pos_y;
         disc_vel_x[loaded_count] = w.vel_x;
         disc_vel_y[loaded_count] = w.vel_y;
         disc_radius[loaded_count] = w.radius;
         disc_mass[loaded_count] = w.mass;
         loaded_count++;
      end
      if (!w.last) return;
      for (int i = 0; i < loaded_count; i++)
         for (int j = i + 1; j < loaded_count; j++) collide_discs(i, j);
      for (int i = 0; i < loaded_count; i++) begin
         r.ball_index = 6'(i);
         r.new_vel_x = disc_vel_x[i];
         r.new_vel_y = disc_vel_y[i];
         r.bounce_total = bounce_count;
         r.last_result = (i + 1 == loaded_count);
         expected_velocities.insert(expected_velocities.size(), r);
      end
      loaded_count = 0;
      sets_done++;
   endfunction

   initial begin
      req_if.valid = 1'b0;
      req_if.pos_x = '0;
      req_if.pos_y = '0;
      req_if.vel_x = '0;
      req_if.vel_y = '0;
      req_if.radius = '0;
      req_if.mass = '0;
      req_if.last = 1'b0;
      rsp_if.ready = 1'b0;
   end

   task automatic send_disc(disc_word_type w);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.pos_x <= w.pos_x;
      req_if.pos_y <= w.pos_y;
      req_if.vel_x <= w.vel_x;
      req_if.vel_y <= w.vel_y;
      req_if.radius <= w.radius;
      req_if.mass <= w.mass;
      req_if.last <= w.last;
      do @(posedge clock); while (!req_if.ready);
      predict_disc(w);
      words_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_velocities.size() == 0) begin
               $display("%t unexpected word: index %0d vx %h vy %h bounces %0d", $time,
                        rsp_if.ball_index, rsp_if.new_vel_x, rsp_if.new_vel_y,
                        rsp_if.bounce_total);
               error_count++;
            end else begin
               velocity_word_type e;
               e = expected_velocities.pop_front();
               if (rsp_if.ball_index !== e.ball_index ||
                   rsp_if.new_vel_x !== e.new_vel_x ||
                   rsp_if.new_vel_y !== e.new_vel_y ||
                   rsp_if.bounce_total !== e.bounce_total ||
                   rsp_if.last_result !== e.last_result) begin
                  $display("%t mismatch: expected idx %0d vx %h vy %h b %0d l %b", $time,
                           e.ball_index, e.new_vel_x, e.new_vel_y, e.bounce_total,
                           e.last_result);
                  $display("%t            actual idx %0d vx %h vy %h b %0d l %b", $time,
                           rsp_if.ball_index, rsp_if.new_vel_x, rsp_if.new_vel_y,
                           rsp_if.bounce_total, rsp_if.last_result);
                  error_count++;
               end
            end
            results_seen++;
         end
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         int s;
         s = $urandom_range(0, 8);
         if ($urandom_range(0, 3) == 0) s = 0;
         stall_left <= s;
         rsp_if.ready <= (s == 0);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_velocities.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_watched(logic [5:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      watched_index = value;
   endtask

   function automatic disc_word_type random_disc(bit last, bit clustered);
      disc_word_type w;
      if (clustered) begin
         w.pos_x = 16'(1000 + $urandom_range(0, 400));
         w.pos_y = 16'(1000 + $urandom_range(0, 400));
         w.radius = 10'($urandom_range(40, 300));
      end else begin
         w.pos_x = 16'($urandom);
         w.pos_y = 16'($urandom);
         w.radius = 10'($urandom);
      end
      w.vel_x = 16'($urandom);
      w.vel_y = 16'($urandom);
      w.mass = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom);
      w.last = last;
      return w;
   endfunction

   task automatic send_set(int n, bit clustered);
      for (int i = 0; i < n; i++) send_disc(random_disc(i == n - 1, clustered));
   endtask

   task automatic test_extremes();
      disc_word_type w;
      write_watched(6'd0);
      w = '{16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 10'h3FF, 16'hFFFF, 1'b0};
      send_disc(w);
      w = '{16'hFFF0, 16'hFFF8, 16'h8000, 16'h7FFF, 10'h3FF, 16'h0001, 1'b1};
      send_disc(w);
      w = '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 10'h000, 16'h0001, 1'b1};
      send_disc(w);
      w = '{16'd100, 16'd100, 16'h0100, 16'h0000, 10'd50, 16'h0000, 1'b0};
      send_disc(w);
      w = '{16'd120, 16'd100, 16'hFF00, 16'h0040, 10'd50, 16'h0000, 1'b1};
      send_disc(w);
   endtask

   task automatic test_chain_and_watch();
      disc_word_type w;
      write_watched(6'd63);
      send_set(4, 1'b1);
      write_watched(6'd2);
      for (int i = 0; i < 5; i++) begin
         w = '{16'(200 + 30 * i), 16'd500, 16'(i * 256), 16'(-i * 64), 10'd20,
               16'(256 * (i + 1)), 1'b0};
         w.last = (i == 4);
         send_disc(w);
      end
   endtask

   task automatic test_overflow_set();
      write_watched(6'd63);
      for (int i = 0; i < 66; i++) send_disc(random_disc(i == 65, i < 20));
      drain_results();
      send_set(64, 1'b1);
   endtask

   task automatic test_random_sets();
      int sent;
      sent = 0;
      while (sent < 250) begin
         int n;
         n = $urandom_range(1, 12);
         if ($urandom_range(0, 4) == 0) write_watched(6'($urandom_range(0, 11)));
         send_set(n, $urandom_range(0, 3) != 0);
         sent += n;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_chain_and_watch();
      test_random_sets();
      test_overflow_set();
      drain_results();
      $display("Sent %0d disc words in %0d sets and checked %0d velocity words.",
               words_sent, sets_done, results_seen);
      $display("Covered extreme fields, zero masses, a watched chain, random sets and overflow.");
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #400ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
